>>> sv/assert_macros.svh
// Assertion macros shared by the engine start sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ESS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition in one cycle implies another in the same cycle.
`define ESS_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ESS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> sv/ess_pkg.sv
// Types, constants and helper functions for the engine start sequencer.
package ess_pkg;

   localparam logic [10:0] ESC_MIN_US   = 11'd1000;
   localparam logic [10:0] ESC_MAX_US   = 11'd2000;
   localparam logic [15:0] STEP_WAIT_MS = 16'd2000;
   localparam logic [15:0] LONG_WAIT_MS = 16'd10000;
   localparam logic [15:0] PERIOD_MIN   = 16'd200;
   localparam logic [15:0] PERIOD_MAX   = 16'd60000;
   localparam logic [15:0] MS_SAT       = 16'hFFFF;
   localparam logic [6:0]  PCT_MAX      = 7'd100;

   localparam logic [6:0]  PCT_STEP10   = 7'd10;
   localparam logic [6:0]  PCT_STEP20   = 7'd20;
   localparam logic [6:0]  PCT_STEP30   = 7'd30;
   localparam logic [6:0]  PCT_STEP50   = 7'd50;

   localparam logic [6:0]  AUTO_ESC_RESET   = 7'd80;
   localparam logic [15:0] SPARK_PER_RESET  = 16'd2000;
   localparam logic [6:0]  AUTO_PUMP_RESET  = 7'd50;

   localparam int unsigned PUMP_MIN = 106;
   localparam int unsigned PUMP_MAX = 255;
   localparam int unsigned PUMP_DEN = 198;

   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_ESC    = 3'd1,
      FUNC_PUMP   = 3'd2,
      FUNC_SPARK  = 3'd3,
      FUNC_MODE   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      CSR_AUTO_ESC   = 2'd0,
      CSR_SPARK_PER  = 2'd1,
      CSR_AUTO_PUMP  = 2'd2
   } csr_addr_type;

   typedef enum logic [3:0] {
      STAGE_IDLE       = 4'd0,
      STAGE_ARM        = 4'd1,
      STAGE_ESC10      = 4'd2,
      STAGE_ESC20      = 4'd3,
      STAGE_ESC30      = 4'd4,
      STAGE_NOISE      = 4'd5,
      STAGE_AUTO_SET   = 4'd6,
      STAGE_AUTO_HOLD  = 4'd7,
      STAGE_SPARK_ON   = 4'd8,
      STAGE_SPARK_WAIT = 4'd9,
      STAGE_RUN        = 4'd10
   } stage_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] value;
      logic [7:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_write_type;

   // Member order puts esc_pulse_us in the lowest bits when packed.
   typedef struct packed {
      logic [3:0]  stage_out;
      logic        manual_out;
      logic        spark_out;
      logic [7:0]  pump_duty;
      logic [10:0] esc_pulse_us;
   } rsp_type;

   typedef logic [127:0][7:0] pump_table_type;

   function automatic logic [6:0] clamp_pct(input logic [7:0] p);
      clamp_pct = (p > {1'b0, PCT_MAX}) ? PCT_MAX : p[6:0];
   endfunction

   // 1000 + 10 * p, as two shifts and two adds.
   function automatic logic [10:0] pulse_of(input logic [6:0] p);
      pulse_of = ESC_MIN_US + ({4'b0, p} << 3) + ({4'b0, p} << 1);
   endfunction

   // Rounded pump map, worked out once at elaboration.
   function automatic pump_table_type build_pump_table();
      pump_table_type t;
      int unsigned    p;
      int unsigned    num;
      for (int i = 0; i < 128; i++) begin
         p = (i > 100) ? 100 : i;
         if (p == 0) begin
            t[i] = 8'd0;
         end else begin
            num  = (p - 1) * (PUMP_MAX - PUMP_MIN);
            t[i] = 8'(PUMP_MIN + (2 * num + PUMP_DEN / 2) / PUMP_DEN);
         end
      end
      return t;
   endfunction

   localparam pump_table_type PUMP_TABLE = build_pump_table();

endpackage

>>> sv/ess_core.sv
// Sequencer state, configuration registers and the per-event update logic.
`include "assert_macros.svh"

module ess_core
   import ess_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_type       req,
   input  csr_write_type csr,
   output rsp_type       result
);

   logic        manual_ff, manual_in;
   stage_type   stage_ff, stage_in;
   logic [10:0] esc_now_ff, esc_now_in;
   logic [10:0] esc_target_ff, esc_target_in;
   logic [7:0]  pump_ff, pump_in;
   logic        spark_ff, spark_in;
   logic        spark_en_ff, spark_en_in;
   logic [15:0] stage_ms_ff, stage_ms_in;
   logic [15:0] spark_ms_ff, spark_ms_in;

   logic [6:0]  auto_esc_ff, auto_esc_in;
   logic [15:0] spark_per_ff, spark_per_in;
   logic [6:0]  auto_pump_ff, auto_pump_in;

   logic [16:0] stage_sum;
   logic [16:0] spark_sum;
   logic [15:0] stage_ms_acc;
   logic [15:0] spark_ms_acc;
   logic        mode_on;
   logic        stage_go;
   logic [6:0]  value_pct;

   assign stage_sum    = {1'b0, stage_ms_ff} + {9'b0, req.elapsed_ms};
   assign spark_sum    = {1'b0, spark_ms_ff} + {9'b0, req.elapsed_ms};
   assign stage_ms_acc = stage_sum[16] ? MS_SAT : stage_sum[15:0];
   assign spark_ms_acc = spark_sum[16] ? MS_SAT : spark_sum[15:0];
   assign mode_on      = (req.value == 8'd1) || (req.value == 8'hFF);
   assign value_pct    = clamp_pct(req.value);

   // Next stage: mode switches and timed advances of the auto sequence.
   always_comb begin
      stage_in = stage_ff;
      stage_go = 1'b0;
      if (step && req.func == FUNC_MODE) begin
         if (mode_on && manual_ff) begin
            stage_in = STAGE_ARM;
         end else if (!mode_on && !manual_ff) begin
            stage_in = STAGE_IDLE;
         end
      end else if (step && req.func == FUNC_TICK && !manual_ff) begin
         unique case (stage_ff) inside
            STAGE_ARM, STAGE_AUTO_SET, STAGE_SPARK_ON: begin
               stage_go = 1'b1;
            end
            STAGE_ESC10, STAGE_ESC20, STAGE_ESC30, STAGE_SPARK_WAIT: begin
               stage_go = stage_ms_acc > STEP_WAIT_MS;
            end
            STAGE_NOISE, STAGE_AUTO_HOLD: begin
               stage_go = stage_ms_acc > LONG_WAIT_MS;
            end
            default: begin
               stage_go = 1'b0;
            end
         endcase
         if (stage_go) begin
            stage_in = stage_type'(stage_ff + 4'd1);
         end
      end
   end

   // Drive outputs and the remaining state for the accepted event.
   always_comb begin
      manual_in     = manual_ff;
      esc_now_in    = esc_now_ff;
      esc_target_in = esc_target_ff;
      pump_in       = pump_ff;
      spark_in      = spark_ff;
      spark_en_in   = spark_en_ff;
      stage_ms_in   = stage_ms_ff;
      spark_ms_in   = spark_ms_ff;
      if (step) begin
         case (req.func)
            FUNC_TICK: begin
               stage_ms_in = stage_ms_acc;
               spark_ms_in = spark_ms_acc;
               if (esc_now_ff < esc_target_ff) begin
                  esc_now_in = esc_now_ff + 11'd1;
               end else if (esc_now_ff > esc_target_ff) begin
                  esc_now_in = esc_now_ff - 11'd1;
               end
               if (stage_go) begin
                  case (stage_ff)
                     STAGE_ARM: begin
                        esc_target_in = pulse_of(PCT_STEP10);
                        stage_ms_in   = 16'd0;
                     end
                     STAGE_ESC10: begin
                        esc_target_in = pulse_of(PCT_STEP20);
                        stage_ms_in   = 16'd0;
                     end
                     STAGE_ESC20: begin
                        esc_target_in = pulse_of(PCT_STEP30);
                        stage_ms_in   = 16'd0;
                     end
                     STAGE_ESC30: begin
                        esc_target_in = pulse_of(PCT_STEP50);
                        stage_ms_in   = 16'd0;
                     end
                     STAGE_AUTO_SET: begin
                        esc_target_in = pulse_of(auto_esc_ff);
                        stage_ms_in   = 16'd0;
                     end
                     STAGE_SPARK_ON: begin
                        spark_en_in = 1'b1;
                        spark_ms_in = 16'd0;
                        stage_ms_in = 16'd0;
                     end
                     STAGE_SPARK_WAIT: begin
                        pump_in = PUMP_TABLE[auto_pump_ff];
                     end
                     default: begin
                     end
                  endcase
               end
               // Toggle spark every half period once it is enabled.
               if (!manual_ff && spark_en_in && spark_ms_in >= {1'b0, spark_per_ff[15:1]}) begin
                  spark_in    = !spark_ff;
                  spark_ms_in = 16'd0;
               end
            end
            FUNC_ESC: begin
               if (manual_ff) begin
                  if (req.value == 8'd0) begin
                     esc_target_in = ESC_MIN_US;
                     esc_now_in    = ESC_MIN_US;
                  end else begin
                     esc_target_in = pulse_of(value_pct);
                  end
               end
            end
            FUNC_PUMP: begin
               if (manual_ff) begin
                  pump_in = PUMP_TABLE[value_pct];
               end
            end
            FUNC_SPARK: begin
               if (manual_ff) begin
                  spark_in = mode_on;
               end
            end
            FUNC_MODE: begin
               if (mode_on == manual_ff) begin
                  manual_in     = !mode_on;
                  esc_target_in = ESC_MIN_US;
                  esc_now_in    = ESC_MIN_US;
                  pump_in       = 8'd0;
                  spark_in      = 1'b0;
                  spark_en_in   = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration is taken in manual mode only.
   always_comb begin
      auto_esc_in  = auto_esc_ff;
      spark_per_in = spark_per_ff;
      auto_pump_in = auto_pump_ff;
      if (csr.valid && manual_ff) begin
         case (csr.index)
            CSR_AUTO_ESC: begin
               auto_esc_in = clamp_pct({1'b0, csr.data[6:0]});
            end
            CSR_SPARK_PER: begin
               if (csr.data < PERIOD_MIN) begin
                  spark_per_in = PERIOD_MIN;
               end else if (csr.data > PERIOD_MAX) begin
                  spark_per_in = PERIOD_MAX;
               end else begin
                  spark_per_in = csr.data;
               end
            end
            CSR_AUTO_PUMP: begin
               auto_pump_in = clamp_pct({1'b0, csr.data[6:0]});
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff     <= 1'b1;
         stage_ff      <= STAGE_IDLE;
         esc_now_ff    <= ESC_MIN_US;
         esc_target_ff <= ESC_MIN_US;
         pump_ff       <= 8'd0;
         spark_ff      <= 1'b0;
         spark_en_ff   <= 1'b0;
         stage_ms_ff   <= 16'd0;
         spark_ms_ff   <= 16'd0;
         auto_esc_ff   <= AUTO_ESC_RESET;
         spark_per_ff  <= SPARK_PER_RESET;
         auto_pump_ff  <= AUTO_PUMP_RESET;
      end else begin
         manual_ff     <= manual_in;
         stage_ff      <= stage_in;
         esc_now_ff    <= esc_now_in;
         esc_target_ff <= esc_target_in;
         pump_ff       <= pump_in;
         spark_ff      <= spark_in;
         spark_en_ff   <= spark_en_in;
         stage_ms_ff   <= stage_ms_in;
         spark_ms_ff   <= spark_ms_in;
         auto_esc_ff   <= auto_esc_in;
         spark_per_ff  <= spark_per_in;
         auto_pump_ff  <= auto_pump_in;
      end
   end

   assign result.esc_pulse_us = esc_now_in;
   assign result.pump_duty    = pump_in;
   assign result.spark_out    = spark_in;
   assign result.manual_out   = manual_in;
   assign result.stage_out    = stage_in;

   `ESS_ASSERT(esc_in_range, esc_now_ff >= ESC_MIN_US && esc_now_ff <= ESC_MAX_US && esc_target_ff >= ESC_MIN_US && esc_target_ff <= ESC_MAX_US, "ESC pulse left its range")
   `ESS_ASSERT_IMP(manual_stage_idle, manual_ff, stage_ff == STAGE_IDLE, "stage active in manual mode")
   `ESS_ASSERT_IMP(spark_enable_late, spark_en_ff, !manual_ff && (stage_ff == STAGE_SPARK_WAIT || stage_ff == STAGE_RUN), "spark enabled outside its stages")
   `ESS_ASSERT(period_in_range, spark_per_ff >= PERIOD_MIN && spark_per_ff <= PERIOD_MAX, "spark period out of range")

endmodule

>>> sv/engine_start_sequencer.sv
// Top level of the engine start sequencer: request and result registers around the core.
//
// Each event transfer (tick, manual ESC, pump or spark command, mode switch) yields one result
// that reports the state after the event. One event is taken every clock cycle while the result
// side is not held by back-pressure; a result passes through the request register and then the
// result register, and both registers advance together so a waiting result never blocks the next
// request while the result side is free. Configuration writes are always accepted
// (csr_ready is always high) and take effect only in manual mode; writes to an index beyond
// the three registers are dropped.
`include "assert_macros.svh"

module engine_start_sequencer
   import ess_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] value, [15:8] elapsed_ms
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] esc_pulse_us, [18:11] pump_duty, [19] spark_out,
                                    // [20] manual_out, [24:21] stage_out, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic          in_valid_ff, in_valid_in;
   req_type       req_ff, req_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          advance;
   logic          step;
   logic          req_xfer;
   csr_write_type csr;
   rsp_type       core_result;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = advance && in_valid_ff;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   ess_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .req    (req_ff),
      .csr    (csr),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      req_in      = req_ff;
      if (req_xfer) begin
         in_valid_in       = 1'b1;
         req_in.func       = req_tuser;
         req_in.value      = req_tdata[7:0];
         req_in.elapsed_ms = req_tdata[15:8];
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_in = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff};

   `ESS_ASSERT_IMP(full_stall_blocks, in_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready, "request taken while both stages are held")
   `ESS_ASSERT_NEXT(step_gives_result, step, rsp_valid_ff, "processed event produced no result")

endmodule
